### hw/rtl/crcfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcfp_pkg;

  localparam int FRAME_BYTES     = 37;
  localparam int BODY_BYTES      = 35;
  localparam int BODY_BITS       = BODY_BYTES * 8;
  localparam int BYTE_IDX_W      = $clog2(FRAME_BYTES);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'h0000;
  localparam logic [15:0] MAX_SEQ_RESET = 16'hFFFF;

  typedef logic [BODY_BITS-1:0]  body_t;
  typedef logic [BYTE_IDX_W-1:0] byte_idx_t;

  // serializer status seen by the top level
  typedef struct packed {
    logic      busy;
    byte_idx_t idx;
  } back_stat_t;

  // one byte of reflected crc-16, lsb first
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/crcfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfp_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_frame_type,
  input  wire logic signed [31:0]   in_data_a,
  input  wire logic signed [31:0]   in_data_b,
  input  wire logic signed [31:0]   in_data_c,
  input  wire logic signed [31:0]   in_data_d,
  input  wire logic signed [31:0]   in_strength_a,
  input  wire logic signed [31:0]   in_strength_b,
  input  wire logic signed [31:0]   in_strength_c,
  input  wire logic signed [31:0]   in_strength_d,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 q_full,
  output logic                      q_push,
  output crcfp_pkg::body_t          q_push_data
);
  import crcfp_pkg::*;

  logic [15:0] max_seq_r, max_seq_nxt;
  logic [15:0] seq_r, seq_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  // frame body, most significant byte first
  assign q_push_data = {seq_r, in_frame_type,
                        in_data_a, in_data_b, in_data_c, in_data_d,
                        in_strength_a, in_strength_b, in_strength_c, in_strength_d};

  always_comb begin
    max_seq_nxt = max_seq_r;
    if (cfg_valid && cfg_ready) begin
      max_seq_nxt = cfg_data;
    end
    seq_nxt = seq_r;
    if (q_push) begin
      // a counter at or above the maximum wraps to zero
      if (seq_r < max_seq_r) begin
        seq_nxt = seq_r + 16'd1;
      end else begin
        seq_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_seq_r <= MAX_SEQ_RESET;
      seq_r     <= 16'd0;
    end else begin
      max_seq_r <= max_seq_nxt;
      seq_r     <= seq_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crcfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfp_queue #(
  parameter int Depth = crcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  crcfp_pkg::body_t      push_data,
  input  wire logic             pop,
  output crcfp_pkg::body_t      head_data,
  output logic                  full,
  output logic                  empty
);
  import crcfp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  body_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FullCnt);
  assign empty     = (cnt_r == '0);
  assign head_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crcfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  crcfp_pkg::body_t         q_head_data,
  input  wire logic                q_empty,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_frame_end,
  output crcfp_pkg::back_stat_t    stat
);
  import crcfp_pkg::*;

  localparam byte_idx_t LastIdx  = BYTE_IDX_W'(FRAME_BYTES - 1);
  localparam byte_idx_t CrcHiIdx = BYTE_IDX_W'(BODY_BYTES);

  logic        busy_r, busy_nxt;
  byte_idx_t   idx_r, idx_nxt;
  body_t       body_r, body_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        oend_r, oend_nxt;

  logic        advance;
  logic        last;
  logic [7:0]  cur_byte;

  assign out_valid     = ovalid_r;
  assign out_byte      = obyte_r;
  assign out_frame_end = oend_r;
  assign stat          = '{busy: busy_r, idx: idx_r};

  // output register is free or being emptied this cycle
  assign advance = busy_r && (!ovalid_r || !out_stall);
  assign last    = (idx_r == LastIdx);

  always_comb begin
    if (idx_r < CrcHiIdx) begin
      cur_byte = body_r[BODY_BITS-1 -: 8];
    end else if (idx_r == CrcHiIdx) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = crc_r[7:0];
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    body_nxt   = body_r;
    crc_nxt    = crc_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    oend_nxt   = oend_r;
    q_pop      = 1'b0;

    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    if (advance) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      oend_nxt   = last;
      idx_nxt    = idx_r + 1'b1;
      if (idx_r < CrcHiIdx) begin
        crc_nxt  = crc_arc_byte(crc_r, cur_byte);
        body_nxt = body_r << 8;
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end

    // load the next frame as soon as the current one is finished
    if ((!busy_r || (advance && last)) && !q_empty) begin
      q_pop    = 1'b1;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      body_nxt = q_head_data;
      crc_nxt  = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    body_r  <= body_nxt;
    crc_r   <= crc_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
    idx_r   <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crc16_sequenced_frame_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame packer: each accepted request (type byte plus eight 32-bit words) becomes a
// 37-byte frame sent one byte per cycle while out_stall is low, msb first: 16-bit
// sequence number, type, the eight words, then a CRC-16/ARC over the first 35 bytes
// (high byte, then low byte, flagged by out_frame_end). The byte-wide output
// serializer sets the rate. Requests are stamped with the sequence number on
// acceptance and parked in a small frame queue (QUEUE_DEPTH entries), so in_stall
// rises only when that queue is full. A request goes from the frame queue to the
// serializer's body register, then its bytes to the output register. The sequence
// counter wraps to zero after reaching max_sequence (cfg_data); cfg_ready is always
// high and the register should only be written while idle.
module crc16_sequenced_frame_packer_top #(
  parameter int QUEUE_DEPTH = crcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_frame_type,
  input  wire logic signed [31:0] in_data_a,
  input  wire logic signed [31:0] in_data_b,
  input  wire logic signed [31:0] in_data_c,
  input  wire logic signed [31:0] in_data_d,
  input  wire logic signed [31:0] in_strength_a,
  input  wire logic signed [31:0] in_strength_b,
  input  wire logic signed [31:0] in_strength_c,
  input  wire logic signed [31:0] in_strength_d,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_frame_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import crcfp_pkg::*;

  logic       q_push, q_pop, q_full, q_empty;
  body_t      q_push_data, q_head_data;
  back_stat_t bk_stat;

  crcfp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_type (in_frame_type),
    .in_data_a     (in_data_a),
    .in_data_b     (in_data_b),
    .in_data_c     (in_data_c),
    .in_data_d     (in_data_d),
    .in_strength_a (in_strength_a),
    .in_strength_b (in_strength_b),
    .in_strength_c (in_strength_c),
    .in_strength_d (in_strength_d),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  crcfp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  crcfp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head_data   (q_head_data),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .stat          (bk_stat)
  );

  // serializer never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("frame queue popped while empty");

  // byte index stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> (bk_stat.idx <= BYTE_IDX_W'(FRAME_BYTES - 1)))
    else $error("serializer byte index past end of frame");

  // a new frame only loads while the serializer is idle or sending its last byte
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && bk_stat.busy |-> (bk_stat.idx == BYTE_IDX_W'(FRAME_BYTES - 1)))
    else $error("frame loaded while serializer busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !bk_stat.busy)
    else $error("output active right after reset");

endmodule

`default_nettype wire

### dv/crc16_frame_packer_monitor.sv
`timescale 1ns / 1ps

module crc16_frame_packer_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_frame_type,
  input  logic signed [31:0] in_data_a,
  input  logic signed [31:0] in_data_b,
  input  logic signed [31:0] in_data_c,
  input  logic signed [31:0] in_data_d,
  input  logic signed [31:0] in_strength_a,
  input  logic signed [31:0] in_strength_b,
  input  logic signed [31:0] in_strength_c,
  input  logic signed [31:0] in_strength_d,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_byte,
  input  logic               out_frame_end,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 bytes_pending
);

  localparam logic [15:0] ARC_POLY   = 16'hA001;
  localparam int          FRAME_LEN  = crcfp_pkg::FRAME_BYTES;
  localparam int          CRC_SPAN   = crcfp_pkg::BODY_BYTES;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  frame_byte_t head_byte;
  logic [15:0] max_seq;
  logic [15:0] next_seq;

  initial begin
    mismatches    = 0;
    bytes_pending = 0;
    max_seq       = 16'hFFFF;
    next_seq      = 16'h0000;
  end

  // reflected crc, one data bit per step, lsb first
  function automatic logic [15:0] arc_crc_update(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ data[i]) begin
        r = {1'b0, r[15:1]} ^ ARC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // expected bytes of the frame for the request taken at this edge
  task automatic queue_frame();
    logic [31:0] words [8];
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] crc;
    words = '{in_data_a, in_data_b, in_data_c, in_data_d,
              in_strength_a, in_strength_b, in_strength_c, in_strength_d};
    frame[0] = next_seq[15:8];
    frame[1] = next_seq[7:0];
    frame[2] = in_frame_type;
    for (int w = 0; w < 8; w++) begin
      for (int b = 0; b < 4; b++) begin
        frame[3 + 4 * w + b] = words[w][31 - 8 * b -: 8];
      end
    end
    crc = 16'h0000;
    for (int i = 0; i < CRC_SPAN; i++) begin
      crc = arc_crc_update(crc, frame[i]);
    end
    frame[FRAME_LEN - 2] = crc[15:8];
    frame[FRAME_LEN - 1] = crc[7:0];
    for (int i = 0; i < FRAME_LEN; i++) begin
      expected_bytes.push_back('{frame[i], (i == FRAME_LEN - 1)});
    end
    // counter above the maximum still wraps to zero
    next_seq = (next_seq < max_seq) ? next_seq + 16'd1 : 16'd0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_seq  = 16'hFFFF;
      next_seq = 16'h0000;
      expected_bytes.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end=%b", out_byte, out_frame_end));
        end else begin
          head_byte = expected_bytes.pop_front();
          if (out_byte !== head_byte.value) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, head_byte.value));
          end
          if (out_frame_end !== head_byte.is_last) begin
            report_mismatch($sformatf("out_frame_end %b, expected %b",
                                      out_frame_end, head_byte.is_last));
          end
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        max_seq = cfg_data;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        queue_frame();
      end
    end
    bytes_pending <= expected_bytes.size();
  end

endmodule

### dv/crc16_sequenced_frame_packer_top_tb.sv
`timescale 1ns / 1ps

module crc16_sequenced_frame_packer_top_tb;

  localparam int CHUNK_ITEMS = 35;
  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_frame_type = '0;
  logic signed [31:0] in_data_a = '0;
  logic signed [31:0] in_data_b = '0;
  logic signed [31:0] in_data_c = '0;
  logic signed [31:0] in_data_d = '0;
  logic signed [31:0] in_strength_a = '0;
  logic signed [31:0] in_strength_b = '0;
  logic signed [31:0] in_strength_c = '0;
  logic signed [31:0] in_strength_d = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_frame_end;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  int mismatches;
  int bytes_pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  logic [31:0] word_buf [8];

  crc16_sequenced_frame_packer_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_type (in_frame_type),
    .in_data_a     (in_data_a),
    .in_data_b     (in_data_b),
    .in_data_c     (in_data_c),
    .in_data_d     (in_data_d),
    .in_strength_a (in_strength_a),
    .in_strength_b (in_strength_b),
    .in_strength_c (in_strength_c),
    .in_strength_d (in_strength_d),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  crc16_frame_packer_monitor frame_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_type (in_frame_type),
    .in_data_a     (in_data_a),
    .in_data_b     (in_data_b),
    .in_data_c     (in_data_c),
    .in_data_d     (in_data_d),
    .in_strength_a (in_strength_a),
    .in_strength_b (in_strength_b),
    .in_strength_c (in_strength_c),
    .in_strength_d (in_strength_d),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offers one request from word_buf; valid stays high on return
  task automatic send_frame(input logic [7:0] kind);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_type <= kind;
    in_data_a     <= word_buf[0];
    in_data_b     <= word_buf[1];
    in_data_c     <= word_buf[2];
    in_data_d     <= word_buf[3];
    in_strength_a <= word_buf[4];
    in_strength_b <= word_buf[5];
    in_strength_c <= word_buf[6];
    in_strength_d <= word_buf[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      foreach (word_buf[i]) word_buf[i] = pick_word();
      send_frame(pick_type());
    end
  endtask

  task automatic send_uniform(input logic [7:0] kind, input logic [31:0] word);
    foreach (word_buf[i]) word_buf[i] = word;
    send_frame(kind);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic write_max_seq(input logic [15:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes under the reset maximum
    send_uniform(8'h00, 32'h0000_0000);
    send_uniform(8'hFF, 32'hFFFF_FFFF);
    send_uniform(8'h7F, 32'h7FFF_FFFF);
    send_uniform(8'h80, 32'h8000_0000);
    foreach (word_buf[i]) word_buf[i] = i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
    send_frame(8'hAA);
    foreach (word_buf[i]) word_buf[i] = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
    send_frame(8'h55);
    // distinct bytes expose byte order
    foreach (word_buf[i]) word_buf[i] = {8'(4 * i + 1), 8'(4 * i + 2), 8'(4 * i + 3), 8'(4 * i + 4)};
    send_frame(8'h01);
    foreach (word_buf[i]) word_buf[i] = 32'h1 << (4 * i + 1);
    send_frame(8'h02);
    wait_drained();

    // maximum of zero pins the sequence at zero
    write_max_seq(16'h0000);
    send_random(3);
    wait_drained();
    write_max_seq(16'd2);
    send_random(5);
    wait_drained();
    // counter now above the new maximum
    write_max_seq(16'd1);
    send_random(3);
    wait_drained();

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        case (chunk)
          0: write_max_seq(16'hFFFF);
          1: write_max_seq(16'($urandom_range(1, 6)));
          2: write_max_seq(16'h0000);
          default: write_max_seq(16'($urandom_range(65535)));
        endcase
        if (chunk == 0 && regime != 1) begin
          holds_requested <= holds_requested + 1;
        end
        send_random(CHUNK_ITEMS);
        wait_drained();
      end
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/crcfp_pkg.sv
hw/rtl/crcfp_front.sv
hw/rtl/crcfp_queue.sv
hw/rtl/crcfp_back.sv
hw/rtl/crc16_sequenced_frame_packer_top.sv
dv/crc16_frame_packer_monitor.sv
dv/crc16_sequenced_frame_packer_top_tb.sv
